>>> rtl/irt_pkg.sv
// Package for the inertia rotation transform: widths, word types and rounding helpers.
// Depends on nothing; every other file of the block imports it.
package irt_pkg;

    localparam int Q_W  = 16;
    localparam int T_W  = 32;
    localparam int QP_W = 32;
    localparam int RV_W = 34;
    localparam int R_W  = 19;
    localparam int P1_W = 51;
    localparam int A1_W = 53;
    localparam int C_W  = 38;
    localparam int P2_W = 57;
    localparam int A2_W = 59;
    localparam int FRAC = 15;
    localparam int N_OUT = 6;

    typedef logic signed [Q_W-1:0]  quat_t;
    typedef logic signed [T_W-1:0]  ten_t;
    typedef logic signed [QP_W-1:0] qprod_t;
    typedef logic signed [RV_W-1:0] rval_t;
    typedef logic signed [R_W-1:0]  rot_t;
    typedef logic signed [P1_W-1:0] prod1_t;
    typedef logic signed [A1_W-1:0] acc1_t;
    typedef logic signed [C_W-1:0]  cval_t;
    typedef logic signed [P2_W-1:0] prod2_t;
    typedef logic signed [A2_W-1:0] acc2_t;

    localparam rval_t ONE_Q30 = RV_W'(64'sd1073741824);

    typedef int unsigned idx3_t [3][3];
    localparam idx3_t SYM_IDX = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

    typedef int unsigned pair_t [N_OUT];
    localparam pair_t PAIR_I = '{0, 0, 0, 1, 1, 2};
    localparam pair_t PAIR_J = '{0, 1, 2, 1, 2, 2};

    function automatic rot_t round_rot(input rval_t v);
        rval_t t;
        t = v + RV_W'(1 << (FRAC - 1));
        return t[RV_W-1:FRAC];
    endfunction

    function automatic cval_t round_c(input acc1_t v);
        acc1_t t;
        t = v + A1_W'(1 << (FRAC - 1));
        return t[A1_W-1:FRAC];
    endfunction

    function automatic ten_t round_sat(input acc2_t v);
        acc2_t t;
        logic signed [A2_W-FRAC-1:0] s;
        t = v + A2_W'(1 << (FRAC - 1));
        s = t[A2_W-1:FRAC];
        if (s > (A2_W-FRAC)'(64'sd2147483647))
            return ten_t'(32'h7fff_ffff);
        else if (s < -(A2_W-FRAC)'(64'sd2147483648))
            return ten_t'(32'h8000_0000);
        else
            return s[T_W-1:0];
    endfunction

endpackage

>>> rtl/irt_in_if.sv
// Input channel of the inertia rotation transform: one tensor and one quaternion per word.
// Depends on irt_pkg.
interface irt_in_if import irt_pkg::*; ();
    logic  valid;
    logic  ready;
    ten_t  i_xx;
    ten_t  i_xy;
    ten_t  i_xz;
    ten_t  i_yy;
    ten_t  i_yz;
    ten_t  i_zz;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    quat_t quat_w;

    modport source (output valid, i_xx, i_xy, i_xz, i_yy, i_yz, i_zz,
                    quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, i_xx, i_xy, i_xz, i_yy, i_yz, i_zz,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> rtl/irt_out_if.sv
// Output channel of the inertia rotation transform: the six rotated entries per word.
// Depends on irt_pkg.
interface irt_out_if import irt_pkg::*; ();
    logic valid;
    logic ready;
    ten_t r_xx;
    ten_t r_xy;
    ten_t r_xz;
    ten_t r_yy;
    ten_t r_yz;
    ten_t r_zz;

    modport source (output valid, r_xx, r_xy, r_xz, r_yy, r_yz, r_zz, input ready);
    modport sink (input valid, r_xx, r_xy, r_xz, r_yy, r_yz, r_zz, output ready);
endinterface

>>> rtl/irt_rotmat.sv
// Two pipeline stages: quaternion products, then the rounded rotation matrix.
// The tensor travels alongside. Depends on irt_pkg.
module irt_rotmat import irt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  quat_t qx,
    input  quat_t qy,
    input  quat_t qz,
    input  quat_t qw,
    input  ten_t  ten_in [6],
    output logic  valid_out,
    output rot_t  rot_out [9],
    output ten_t  ten_out [6]
);

    logic   v1_reg;
    logic   v2_reg;
    qprod_t pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg, pxw_reg, pyw_reg, pzw_reg;
    ten_t   ten1_reg [6];
    ten_t   ten2_reg [6];
    rot_t   rot_reg [9];
    rot_t   rot_next [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg  <= QP_W'(qx) * QP_W'(qx);
            pyy_reg  <= QP_W'(qy) * QP_W'(qy);
            pzz_reg  <= QP_W'(qz) * QP_W'(qz);
            pxy_reg  <= QP_W'(qx) * QP_W'(qy);
            pxz_reg  <= QP_W'(qx) * QP_W'(qz);
            pyz_reg  <= QP_W'(qy) * QP_W'(qz);
            pxw_reg  <= QP_W'(qx) * QP_W'(qw);
            pyw_reg  <= QP_W'(qy) * QP_W'(qw);
            pzw_reg  <= QP_W'(qz) * QP_W'(qw);
            ten1_reg <= ten_in;
            ten2_reg <= ten1_reg;
            rot_reg  <= rot_next;
        end
    end

    always_comb
    begin
        rot_next[0] = round_rot(ONE_Q30 - ((RV_W'(pyy_reg) + RV_W'(pzz_reg)) <<< 1));
        rot_next[1] = round_rot((RV_W'(pxy_reg) - RV_W'(pzw_reg)) <<< 1);
        rot_next[2] = round_rot((RV_W'(pxz_reg) + RV_W'(pyw_reg)) <<< 1);
        rot_next[3] = round_rot((RV_W'(pxy_reg) + RV_W'(pzw_reg)) <<< 1);
        rot_next[4] = round_rot(ONE_Q30 - ((RV_W'(pxx_reg) + RV_W'(pzz_reg)) <<< 1));
        rot_next[5] = round_rot((RV_W'(pyz_reg) - RV_W'(pxw_reg)) <<< 1);
        rot_next[6] = round_rot((RV_W'(pxz_reg) - RV_W'(pyw_reg)) <<< 1);
        rot_next[7] = round_rot((RV_W'(pyz_reg) + RV_W'(pxw_reg)) <<< 1);
        rot_next[8] = round_rot(ONE_Q30 - ((RV_W'(pxx_reg) + RV_W'(pyy_reg)) <<< 1));
    end

    assign valid_out = v2_reg;
    assign rot_out   = rot_reg;
    assign ten_out   = ten2_reg;

endmodule

>>> rtl/irt_mul_ri.sv
// Two pipeline stages forming C = R * I: products, then sums rounded to 38-bit
// signed values. The Q15 rotation matrix travels alongside. Depends on irt_pkg.
module irt_mul_ri import irt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  rot_t  rot_in [9],
    input  ten_t  ten_in [6],
    output logic  valid_out,
    output rot_t  rot_out [9],
    output cval_t c_out [9]
);

    logic   v1_reg;
    logic   v2_reg;
    prod1_t prod_reg [9][3];
    prod1_t prod_next [9][3];
    rot_t   rot1_reg [9];
    rot_t   rot2_reg [9];
    cval_t  c_reg [9];
    cval_t  c_next [9];

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            for (genvar k = 0; k < 3; k++)
            begin : g_term
                assign prod_next[i*3+j][k] =
                    P1_W'(rot_in[i*3+k]) * P1_W'(ten_in[SYM_IDX[k][j]]);
            end
            assign c_next[i*3+j] = round_c(A1_W'(prod_reg[i*3+j][0])
                + A1_W'(prod_reg[i*3+j][1]) + A1_W'(prod_reg[i*3+j][2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            rot1_reg <= rot_in;
            rot2_reg <= rot1_reg;
            c_reg    <= c_next;
        end
    end

    assign valid_out = v2_reg;
    assign rot_out   = rot2_reg;
    assign c_out     = c_reg;

endmodule

>>> rtl/irt_mul_crt.sv
// Two pipeline stages forming the upper triangle of C * R^T, rounded and saturated.
// The second stage is the output register. Depends on irt_pkg.
module irt_mul_crt import irt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  rot_t  rot_in [9],
    input  cval_t c_in [9],
    output logic  valid_out,
    output ten_t  res_out [N_OUT]
);

    logic   v1_reg;
    logic   v2_reg;
    prod2_t prod_reg [N_OUT][3];
    prod2_t prod_next [N_OUT][3];
    ten_t   res_reg [N_OUT];
    ten_t   res_next [N_OUT];

    for (genvar n = 0; n < N_OUT; n++)
    begin : g_out
        for (genvar k = 0; k < 3; k++)
        begin : g_term
            assign prod_next[n][k] =
                P2_W'(c_in[PAIR_I[n]*3+k]) * P2_W'(rot_in[PAIR_J[n]*3+k]);
        end
        assign res_next[n] = round_sat(A2_W'(prod_reg[n][0]) + A2_W'(prod_reg[n][1])
            + A2_W'(prod_reg[n][2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            res_reg  <= res_next;
        end
    end

    assign valid_out = v2_reg;
    assign res_out   = res_reg;

endmodule

>>> rtl/inertia_rotation_transform.sv
// Inertia rotation transform, top level: R * I * R^T from a tensor and a unit quaternion.
// An accepted input word passes through the six pipeline stages to its output word.
// The pipeline takes one word per cycle while it advances; it advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset clears the valid bits of all stages; the datapath registers are not reset.
// Depends on irt_pkg, irt_in_if, irt_out_if, irt_rotmat, irt_mul_ri and irt_mul_crt.
module inertia_rotation_transform import irt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    irt_in_if.sink     in_ch,
    irt_out_if.source  out_ch
);

    logic  en;
    logic  rot_valid;
    logic  c_valid;
    ten_t  ten_in [6];
    ten_t  ten_d [6];
    rot_t  rot_a [9];
    rot_t  rot_b [9];
    cval_t c_val [9];
    ten_t  res [N_OUT];

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    assign ten_in[0] = in_ch.i_xx;
    assign ten_in[1] = in_ch.i_xy;
    assign ten_in[2] = in_ch.i_xz;
    assign ten_in[3] = in_ch.i_yy;
    assign ten_in[4] = in_ch.i_yz;
    assign ten_in[5] = in_ch.i_zz;

    irt_rotmat u_rotmat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_ch.valid),
        .qx        (in_ch.quat_x),
        .qy        (in_ch.quat_y),
        .qz        (in_ch.quat_z),
        .qw        (in_ch.quat_w),
        .ten_in    (ten_in),
        .valid_out (rot_valid),
        .rot_out   (rot_a),
        .ten_out   (ten_d)
    );

    irt_mul_ri u_mul_ri (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (rot_valid),
        .rot_in    (rot_a),
        .ten_in    (ten_d),
        .valid_out (c_valid),
        .rot_out   (rot_b),
        .c_out     (c_val)
    );

    irt_mul_crt u_mul_crt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (c_valid),
        .rot_in    (rot_b),
        .c_in      (c_val),
        .valid_out (out_ch.valid),
        .res_out   (res)
    );

    assign out_ch.r_xx = res[0];
    assign out_ch.r_xy = res[1];
    assign out_ch.r_xz = res[2];
    assign out_ch.r_yy = res[3];
    assign out_ch.r_yz = res[4];
    assign out_ch.r_zz = res[5];

    // A stalled pipeline must neither gain nor lose words in its middle stages.
    a_stall_holds_rot: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(rot_valid))
        else $error("rotation stage valid changed during a stall");

    a_stall_holds_c: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(c_valid))
        else $error("product stage valid changed during a stall");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input refused while the output register is empty");

    a_word_reaches_rot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready ##1 en |=> rot_valid)
        else $error("accepted word did not reach the rotation stage");

endmodule
